// ===== rtl/rjb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the reference jitter binner.
`timescale 1ns / 1ps

package rjb_pkg;

    localparam int DELAY_W    = 16;
    localparam int CH_W       = 3;
    localparam int HIST_W     = 3;
    localparam int BIN_W      = 10;
    localparam int WIN_W      = 32;
    localparam int TICK_W     = 33;
    localparam int CFG_ADDR_W = 1;
    localparam int NUM_BINS   = 1024;
    localparam int BIN_CENTER = 511;

    localparam logic [CFG_ADDR_W-1:0] REG_REF_CHANNEL  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_TICKS = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_STEP,
        CELL_SHIFT,
        CELL_DROP
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DELAY_W-1:0]  delay;
        logic                open;
        logic [DELAY_W-1:0]  new_since;
        logic [HIST_W-1:0]   new_hist;
    } cell_ctl_t;

    typedef struct packed {
        logic                occ;
        logic [DELAY_W-1:0]  since;
        logic [DELAY_W-1:0]  till;
        logic [HIST_W-1:0]   hist;
    } cell_data_t;

    function automatic logic [DELAY_W-1:0] sat_add(input logic [DELAY_W-1:0] a,
                                                   input logic [DELAY_W-1:0] b);
        logic [DELAY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DELAY_W] ? {DELAY_W{1'b1}} : s[DELAY_W-1:0];
    endfunction

    // Nearer delay, signed (since positive, until negative, tie positive),
    // offset by the centre bin and clamped to the bin range.
    function automatic logic [BIN_W-1:0] bin_of(input logic [DELAY_W-1:0] since,
                                                input logic [DELAY_W-1:0] till);
        logic signed [DELAY_W+1:0] b;
        if (since > till) begin
            b = -$signed({2'b00, till});
        end else begin
            b = $signed({2'b00, since});
        end
        b = b + (DELAY_W+2)'(BIN_CENTER);
        if (b < 0) begin
            return '0;
        end else if (b > (DELAY_W+2)'(NUM_BINS - 1)) begin
            return BIN_W'(NUM_BINS - 1);
        end else begin
            return b[BIN_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/rjb_cell.sv =====
// One pending-point cell of the binner row: holds delays and histogram of one point.
`timescale 1ns / 1ps

module rjb_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  rjb_pkg::cell_ctl_t  ctl_i,
    input  logic                prev_occ_i,
    input  rjb_pkg::cell_data_t next_i,
    output rjb_pkg::cell_data_t cell_o
);

    logic                        occ_reg,   occ_next;
    logic [rjb_pkg::DELAY_W-1:0] since_reg, since_next;
    logic [rjb_pkg::DELAY_W-1:0] until_reg, until_next;
    logic [rjb_pkg::HIST_W-1:0]  hist_reg,  hist_next;

    always_comb begin
        occ_next   = occ_reg;
        since_next = since_reg;
        until_next = until_reg;
        hist_next  = hist_reg;
        case (ctl_i.op)
            rjb_pkg::CELL_STEP: begin
                if (occ_reg) begin
                    until_next = rjb_pkg::sat_add(until_reg, ctl_i.delay);
                end else if (ctl_i.open && prev_occ_i) begin
                    // first free cell takes the newly opened point
                    occ_next   = 1'b1;
                    since_next = ctl_i.new_since;
                    until_next = '0;
                    hist_next  = ctl_i.new_hist;
                end
            end
            rjb_pkg::CELL_SHIFT: begin
                occ_next   = next_i.occ;
                since_next = next_i.since;
                until_next = next_i.till;
                hist_next  = next_i.hist;
            end
            rjb_pkg::CELL_DROP: begin
                occ_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        since_reg <= since_next;
        until_reg <= until_next;
        hist_reg  <= hist_next;
    end

    assign cell_o = '{occ: occ_reg, since: since_reg, till: until_reg, hist: hist_reg};

endmodule

// ===== rtl/reference_jitter_binner.sv =====
// Reference jitter binner: pending-point cell row, tick window and result output.
// An item that gives no result is taken without entering the drain state; a tick that
// closes a window moves to the drain state to send the window result; for a reference
// word with pending points the cell row drains one point a cycle through cell zero
// (longer if m_tready stalls). Results pass the drain state and the output register.
// Reset is synchronous and active low; it clears control state, no clearing pass.
`timescale 1ns / 1ps

module reference_jitter_binner #(
    parameter int MAX_POINTS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,    // channel[2:0], delay[18:3]
    input  logic [0:0]                       s_tuser,    // is_tick[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,    // hist_id[2:0], bin[12:3]
    output logic [0:0]                       m_tuser,    // kind[0]
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [rjb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rjb_pkg::WIN_W-1:0]        cfg_wr_data
);

    localparam int NCELL    = (MAX_POINTS > 2) ? MAX_POINTS - 2 : 1;
    localparam bit HAS_ROOM = (MAX_POINTS > 2);

    rjb_pkg::state_t             state_reg, state_next;
    logic                        armed_reg;
    logic                        have_acc_reg;
    logic                        win_pend_reg;
    logic [rjb_pkg::TICK_W-1:0]  tick_cnt_reg;
    logic [rjb_pkg::DELAY_W-1:0] acc_since_reg;
    logic [rjb_pkg::CH_W-1:0]    ref_ch_reg;
    logic [rjb_pkg::WIN_W-1:0]   win_ticks_reg;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [15:0]                 m_tdata_reg,  m_tdata_next;
    logic                        m_kind_reg,   m_kind_next;
    logic                        m_tlast_reg,  m_tlast_next;

    rjb_pkg::cell_ctl_t          cell_ctl;
    rjb_pkg::cell_data_t         cell_q [NCELL];
    logic [NCELL-1:0]            occ_vec;
    logic [NCELL:0]              occ_ext;

    logic                        s_tick;
    logic [rjb_pkg::CH_W-1:0]    s_ch;
    logic [rjb_pkg::DELAY_W-1:0] s_dly;
    logic                        accept, armed_now, is_ref, live, open_pt, fire, full;
    logic [rjb_pkg::DELAY_W-1:0] acc_sum;
    logic [rjb_pkg::HIST_W-1:0]  hid;
    logic [rjb_pkg::TICK_W-1:0]  tick_inc, win_lim;
    logic                        out_free, emit_go, emit_pt, emit_win, occ0, occ1;

    // ---- cell row ----
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            rjb_pkg::cell_data_t nxt;
            logic                prv;
            if (gi == NCELL - 1) begin : g_tail
                assign nxt = '0;
            end else begin : g_mid
                assign nxt = cell_q[gi+1];
            end
            if (gi == 0) begin : g_head
                assign prv = 1'b1;
            end else begin : g_body
                assign prv = cell_q[gi-1].occ;
            end
            rjb_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl_i      (cell_ctl),
                .prev_occ_i (prv),
                .next_i     (nxt),
                .cell_o     (cell_q[gi])
            );
            assign occ_vec[gi] = cell_q[gi].occ;
        end
    endgenerate

    assign occ_ext = {1'b0, occ_vec};
    assign occ0    = occ_ext[0];
    assign occ1    = occ_ext[1];
    assign full    = !HAS_ROOM || occ_vec[NCELL-1];

    // ---- input decode ----
    assign s_tick    = s_tuser[0];
    assign s_ch      = s_tdata[2:0];
    assign s_dly     = s_tdata[18:3];
    assign accept    = s_tvalid && s_tready;
    assign armed_now = armed_reg || s_tick;
    assign is_ref    = !s_tick && (s_ch == ref_ch_reg);
    assign live      = accept && armed_now && (is_ref || have_acc_reg);
    assign open_pt   = live && !s_tick && !is_ref && !full;
    assign acc_sum   = rjb_pkg::sat_add(acc_since_reg, s_dly);
    assign hid       = (s_ch > ref_ch_reg) ? rjb_pkg::HIST_W'(s_ch - 1'b1) : s_ch;

    assign tick_inc  = tick_cnt_reg + 1'b1;
    assign win_lim   = (win_ticks_reg == '0) ? rjb_pkg::TICK_W'(1)
                                             : {1'b0, win_ticks_reg};
    assign fire      = accept && armed_now && s_tick && (tick_inc > win_lim);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_go   = (state_reg == rjb_pkg::S_EMIT) && out_free;
    assign emit_pt   = emit_go && occ0;
    assign emit_win  = emit_go && !occ0;

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rjb_pkg::S_IDLE: begin
                if ((live && is_ref && occ0) || fire) begin
                    state_next = rjb_pkg::S_EMIT;
                end
            end
            rjb_pkg::S_EMIT: begin
                if (emit_go && (occ0 ? (!occ1 && !win_pend_reg) : 1'b1)) begin
                    state_next = rjb_pkg::S_IDLE;
                end
            end
            default: state_next = rjb_pkg::S_IDLE;
        endcase
    end

    // ---- outputs: cell control and result word ----
    always_comb begin
        s_tready           = (state_reg == rjb_pkg::S_IDLE);
        cell_ctl.op        = rjb_pkg::CELL_HOLD;
        cell_ctl.delay     = s_dly;
        cell_ctl.open      = open_pt;
        cell_ctl.new_since = acc_sum;
        cell_ctl.new_hist  = hid;
        if (fire) begin
            cell_ctl.op = rjb_pkg::CELL_DROP;
        end else if (live) begin
            cell_ctl.op = rjb_pkg::CELL_STEP;
        end else if (emit_pt) begin
            cell_ctl.op = rjb_pkg::CELL_SHIFT;
        end

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_kind_next   = m_kind_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit_pt) begin
            m_tvalid_next = 1'b1;
            m_kind_next   = 1'b0;
            m_tdata_next  = {3'b000,
                             rjb_pkg::bin_of(cell_q[0].since, cell_q[0].till),
                             cell_q[0].hist};
            m_tlast_next  = !occ1 && !win_pend_reg;
        end else if (emit_win) begin
            m_tvalid_next = 1'b1;
            m_kind_next   = 1'b1;
            m_tdata_next  = '0;
            m_tlast_next  = 1'b1;
        end
    end

    // ---- control registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rjb_pkg::S_IDLE;
            armed_reg     <= 1'b0;
            have_acc_reg  <= 1'b0;
            win_pend_reg  <= 1'b0;
            tick_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            ref_ch_reg    <= '0;
            win_ticks_reg <= rjb_pkg::WIN_W'(5);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept && armed_now) begin
                armed_reg <= 1'b1;
            end
            if (accept && armed_now && s_tick) begin
                tick_cnt_reg <= fire ? rjb_pkg::TICK_W'(1) : tick_inc;
            end
            if (live && is_ref) begin
                have_acc_reg <= 1'b1;
            end
            if (fire) begin
                win_pend_reg <= 1'b1;
            end else if (emit_win) begin
                win_pend_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    rjb_pkg::REG_REF_CHANNEL:  ref_ch_reg    <= cfg_wr_data[2:0];
                    rjb_pkg::REG_WINDOW_TICKS: win_ticks_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_kind_reg  <= m_kind_next;
        m_tlast_reg <= m_tlast_next;
        if (live) begin
            // reference restarts the accumulating slot, anything else advances it
            acc_since_reg <= is_ref ? '0 : acc_sum;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_kind_reg;
    assign m_tlast    = m_tlast_reg;

`ifndef ASSERT_OFF
    // pending points fill the row from cell zero without holes
    a_occ_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_vec & NCELL'(occ_vec + 1'b1)) == '0)
        else $error("pending point row has a hole");

    // drain state always has something left to send
    a_emit_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rjb_pkg::S_EMIT) |-> (occ0 || win_pend_reg))
        else $error("drain state with nothing to send");

    // window result is sent last and ends the drain
    a_win_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_win |=> (state_reg == rjb_pkg::S_IDLE) && m_tlast && m_tuser[0])
        else $error("window result not last or drain not finished");

    // no word taken while a window result is pending
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        win_pend_reg |-> !s_tready)
        else $error("word taken with window result pending");
`endif

endmodule
